@@ hdl/mbrtu_pkg.sv @@
// Package: shared types, constants and CRC function for the Modbus RTU slave engine.
`timescale 1ns / 1ps
`default_nettype none
package mbrtu_pkg;

    localparam int MAP_BYTES_DEF     = 512;
    localparam int MAX_FRAME_DEF     = 256;
    localparam int MIN_FRAME_DEF     = 4;
    localparam int WRITE_REQ_LEN_DEF = 13;
    localparam int READ_REQ_LEN      = 8;
    localparam int HEAD_LEN          = 6;

    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_PULL  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_NORM = 2'd2;
    localparam logic [1:0] ST_EXC  = 2'd3;

    localparam logic [7:0] FN_READ_HOLD  = 8'h03;
    localparam logic [7:0] FN_READ_INPUT = 8'h04;
    localparam logic [7:0] FN_WRITE_MULT = 8'h10;

    localparam logic [7:0] EX_FUNC  = 8'd1;
    localparam logic [7:0] EX_ADDR  = 8'd2;
    localparam logic [7:0] EX_VALUE = 8'd3;
    localparam logic [7:0] EX_BUSY  = 8'd6;
    localparam logic [7:0] EX_TYPE  = 8'd7;
    localparam logic [7:0] EX_BAUD  = 8'd8;

    localparam logic [15:0] HOLD_LIMIT  = 16'h00C8;
    localparam logic [15:0] INPUT_LIMIT = 16'h007D;
    localparam logic [15:0] BOOT_COUNT  = 16'h0002;
    localparam logic [15:0] BOOT_START  = 16'h0438;
    localparam logic [15:0] BAUD_MAX    = 16'd2560;
    localparam logic [7:0]  EXC_FLAG    = 8'h80;

    localparam int CFG_SLAVE = 0;
    localparam int CFG_ALT   = 1;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       map_select;
        logic [8:0] map_address;
        logic       link_lost;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        tx_last;
        logic [1:0]  frame_status;
        logic [7:0]  response_length;
        logic        boot_request;
        logic [1:0]  firmware_type;
        logic [11:0] baud_setting;
    } out_item_t;

    // Control for one pull byte in the output stage.
    typedef struct packed {
        logic       valid;
        logic       from_map;
        logic       last;
        logic [7:0] head_byte;
    } pull_ctl_t;

    // One reflected CRC-16 byte update, poly 0xA001.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hdl/mbrtu_map_mem.sv @@
// Holding and input map memories with registered read and write port.
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_map_mem #(
    parameter int MAP_BYTES = mbrtu_pkg::MAP_BYTES_DEF,
    localparam int AW = $clog2(MAP_BYTES)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic          wr_sel,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic          rd_sel,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);
    import mbrtu_pkg::*;

    logic [7:0] hold_mem [MAP_BYTES];
    logic [7:0] inp_mem  [MAP_BYTES];
    logic [7:0] hold_q_reg;
    logic [7:0] inp_q_reg;
    logic       sel_q_reg;

    // Write the selected map.
    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_sel)
            hold_mem[wr_addr] <= wr_data;
        if (wr_en && wr_sel)
            inp_mem[wr_addr] <= wr_data;
    end

    // Read both maps, pick one after the register.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            hold_q_reg <= hold_mem[rd_addr];
            inp_q_reg  <= inp_mem[rd_addr];
            sel_q_reg  <= rd_sel;
        end
    end

    assign rd_data = sel_q_reg ? inp_q_reg : hold_q_reg;
endmodule
`default_nettype wire

@@ hdl/modbus_rtu_slave_frame_engine_top.sv @@
// Top level: Modbus RTU slave frame engine with request parser and response pull.
// Timing: every item gives its result item in the cycle after acceptance (pull bytes
// come from a registered map memory read, held in the memory output register).
// Throughput: one item per cycle; the input stalls only while the output stage is full
// and not being taken. Reset clears all control state; map contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_slave_frame_engine_top #(
    parameter int MAP_BYTES     = mbrtu_pkg::MAP_BYTES_DEF,
    parameter int MAX_FRAME     = mbrtu_pkg::MAX_FRAME_DEF,
    parameter int MIN_FRAME     = mbrtu_pkg::MIN_FRAME_DEF,
    parameter int WRITE_REQ_LEN = mbrtu_pkg::WRITE_REQ_LEN_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire mbrtu_pkg::in_item_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output mbrtu_pkg::out_item_t      out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [7:0]           cfg_data
);
    import mbrtu_pkg::*;

    localparam int AW = $clog2(MAP_BYTES);
    localparam int CW = $clog2(MAX_FRAME + 2);

    logic [7:0]  slave_reg, alt_reg;
    logic [7:0]  head_reg [WRITE_REQ_LEN];
    logic [CW-1:0] rx_count_reg;
    logic [15:0] rx_crc_reg, rx_tail_reg;
    logic [7:0]  rhead_reg [HEAD_LEN];
    logic [8:0]  tx_pos_reg, tx_len_reg;
    logic [15:0] tx_crc_reg;
    logic [AW-1:0] rbase_reg;
    logic        rinput_reg;

    // output stage: stage 1 holds the result, map byte merged from memory
    logic        s_valid_reg;
    out_item_t   s_item_reg;
    pull_ctl_t   s_pull_reg;
    logic [15:0] s_crc_reg;
    logic        s_crc_feed_reg;

    logic accept;
    logic [7:0] rd_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = s_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= 8'd1;
            alt_reg   <= 8'd1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == 1'(CFG_SLAVE))
                slave_reg <= cfg_data;
            else
                alt_reg <= cfg_data;
        end
    end

    // Frame end decision.
    logic [15:0] f_start, f_count, f_type, f_rate, f_limit;
    logic [1:0]  f_status;
    logic [7:0]  f_code, f_func;
    logic [8:0]  f_len;
    logic        f_boot, f_ok_len, f_crc_ok, f_addr_ok, f_is_read;
    logic [17:0] f_span;

    always_comb
    begin
        f_func   = head_reg[1];
        f_start  = {head_reg[2], head_reg[3]};
        f_count  = {head_reg[4], head_reg[5]};
        f_type   = {head_reg[7], head_reg[8]};
        f_rate   = {head_reg[9], head_reg[10]};
        f_is_read = (f_func == FN_READ_HOLD) || (f_func == FN_READ_INPUT);
        f_limit  = (f_func == FN_READ_HOLD) ? HOLD_LIMIT : INPUT_LIMIT;
        f_span   = ({2'b00, f_start} + {2'b00, f_count}) << 1;
        f_ok_len = (rx_count_reg >= CW'(MIN_FRAME)) && (rx_count_reg <= CW'(MAX_FRAME));
        f_crc_ok = (rx_tail_reg[15:8] == rx_crc_reg[7:0]) && (rx_tail_reg[7:0] == rx_crc_reg[15:8]);
        f_addr_ok = (head_reg[0] == slave_reg) || (head_reg[0] == alt_reg);
        f_status = ST_EXC;
        f_code   = EX_FUNC;
        f_len    = 9'd5;
        f_boot   = 1'b0;
        if (!f_ok_len || !f_crc_ok || !f_addr_ok)
            f_status = ST_DROP;
        else if (f_is_read)
        begin
            if (rx_count_reg != CW'(READ_REQ_LEN))
                f_status = ST_DROP;
            else if (f_count == 16'd0 || f_count > f_limit)
                f_code = EX_VALUE;
            else if (f_span > 18'(MAP_BYTES))
                f_code = EX_ADDR;
            else if (in_data.link_lost)
                f_code = EX_BUSY;
            else
            begin
                f_status = ST_NORM;
                f_len    = 9'(f_count * 2 + 5);
            end
        end
        else if (f_func == FN_WRITE_MULT)
        begin
            if (rx_count_reg != CW'(WRITE_REQ_LEN))
                f_status = ST_DROP;
            else if (f_count != BOOT_COUNT)
                f_code = EX_VALUE;
            else if (f_start != BOOT_START)
                f_code = EX_ADDR;
            else if (in_data.link_lost)
                f_code = EX_BUSY;
            else if (f_type > 16'd2)
                f_code = EX_TYPE;
            else if (f_rate > BAUD_MAX)
                f_code = EX_BAUD;
            else
            begin
                f_status = ST_NORM;
                f_len    = 9'd8;
                f_boot   = 1'b1;
            end
        end
    end

    // Pull decision.
    logic [8:0]  p_data_len;
    logic        p_active, p_from_map, p_feed, p_last;
    logic [7:0]  p_head;
    logic [AW-1:0] p_addr;
    logic [15:0] cur_crc;

    // Forward a CRC update still waiting on its map byte.
    assign cur_crc = s_crc_feed_reg ? crc_feed(s_crc_reg, rd_data) : tx_crc_reg;

    always_comb
    begin
        p_active   = tx_pos_reg < tx_len_reg;
        p_data_len = tx_len_reg - 9'd2;
        p_from_map = 1'b0;
        p_feed     = 1'b0;
        p_last     = 1'b0;
        p_head     = 8'h00;
        p_addr     = AW'(rbase_reg + AW'(tx_pos_reg) - AW'(3));
        if (tx_pos_reg < p_data_len)
        begin
            p_feed = 1'b1;
            if ((rhead_reg[1] == FN_READ_HOLD || rhead_reg[1] == FN_READ_INPUT)
                && tx_pos_reg >= 9'd3)
                p_from_map = 1'b1;
            else if (tx_pos_reg < 9'(HEAD_LEN))
                p_head = rhead_reg[tx_pos_reg[2:0]];
        end
        else if (tx_pos_reg == p_data_len)
            p_head = cur_crc[7:0];
        else
        begin
            p_head = cur_crc[15:8];
            p_last = 1'b1;
        end
    end

    logic pull_go, end_go, rx_go, map_wr;
    assign pull_go = accept && in_data.op == OP_PULL && p_active;
    assign end_go  = accept && in_data.op == OP_END;
    assign rx_go   = accept && in_data.op == OP_RX && rx_count_reg <= CW'(MAX_FRAME);
    assign map_wr  = accept && in_data.op == OP_WRITE
                     && {4'b0000, in_data.map_address} < 13'(MAP_BYTES);

    mbrtu_map_mem #(.MAP_BYTES(MAP_BYTES)) u_map (
        .clk     (clk),
        .wr_en   (map_wr),
        .wr_sel  (in_data.map_select),
        .wr_addr (AW'(in_data.map_address)),
        .wr_data (in_data.data_byte),
        .rd_en   (pull_go && p_from_map),
        .rd_sel  (rinput_reg),
        .rd_addr (p_addr),
        .rd_data (rd_data)
    );

    // Receive and response state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg <= '0;
            rx_crc_reg   <= 16'hFFFF;
            rx_tail_reg  <= 16'h0000;
            tx_pos_reg   <= 9'd0;
            tx_len_reg   <= 9'd0;
            tx_crc_reg   <= 16'hFFFF;
            rbase_reg    <= '0;
            rinput_reg   <= 1'b0;
            for (int i = 0; i < WRITE_REQ_LEN; i++)
                head_reg[i] <= 8'h00;
            for (int i = 0; i < HEAD_LEN; i++)
                rhead_reg[i] <= 8'h00;
        end
        else
        begin
            if (s_crc_feed_reg)
                tx_crc_reg <= cur_crc;
            if (rx_go)
            begin
                if (rx_count_reg >= CW'(2))
                    rx_crc_reg <= crc_feed(rx_crc_reg, rx_tail_reg[15:8]);
                rx_tail_reg <= {rx_tail_reg[7:0], in_data.data_byte};
                for (int i = 0; i < WRITE_REQ_LEN; i++)
                    if (rx_count_reg == CW'(i))
                        head_reg[i] <= in_data.data_byte;
                rx_count_reg <= rx_count_reg + CW'(1);
            end
            if (end_go)
            begin
                rx_count_reg <= '0;
                rx_crc_reg   <= 16'hFFFF;
                rx_tail_reg  <= 16'h0000;
                if (f_status != ST_DROP)
                begin
                    tx_len_reg <= f_len;
                    tx_pos_reg <= 9'd0;
                    tx_crc_reg <= 16'hFFFF;
                    rhead_reg[0] <= slave_reg;
                    if (f_status == ST_EXC)
                    begin
                        rhead_reg[1] <= f_func | EXC_FLAG;
                        rhead_reg[2] <= f_code;
                    end
                    else if (f_boot)
                    begin
                        rhead_reg[1] <= FN_WRITE_MULT;
                        for (int i = 2; i < HEAD_LEN; i++)
                            rhead_reg[i] <= head_reg[i];
                    end
                    else
                    begin
                        rhead_reg[1] <= f_func;
                        rhead_reg[2] <= 8'(f_count << 1);
                        rbase_reg    <= AW'(f_start << 1);
                        rinput_reg   <= (f_func == FN_READ_INPUT);
                    end
                end
            end
            if (pull_go)
            begin
                tx_pos_reg <= tx_pos_reg + 9'd1;
                if (p_feed && !p_from_map)
                    tx_crc_reg <= crc_feed(cur_crc, p_head);
            end
        end
    end

    // Output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg    <= 1'b0;
            s_crc_feed_reg <= 1'b0;
            s_pull_reg     <= '0;
        end
        else
        begin
            s_crc_feed_reg <= 1'b0;
            if (accept)
            begin
                s_valid_reg <= 1'b1;
                s_item_reg  <= '0;
                s_pull_reg  <= '0;
                if (pull_go)
                begin
                    s_pull_reg     <= '{valid: 1'b1, from_map: p_from_map, last: p_last,
                                        head_byte: p_head};
                    s_crc_reg      <= cur_crc;
                    s_crc_feed_reg <= p_from_map;
                end
                if (end_go)
                begin
                    s_item_reg.frame_status <= f_status;
                    if (f_status != ST_DROP)
                        s_item_reg.response_length <= (f_len > 9'd255) ? 8'hFF : f_len[7:0];
                    if (f_status == ST_NORM && f_boot)
                    begin
                        s_item_reg.boot_request  <= 1'b1;
                        s_item_reg.firmware_type <= f_type[1:0];
                        s_item_reg.baud_setting  <= f_rate[11:0];
                    end
                end
            end
            else if (!out_stall)
                s_valid_reg <= 1'b0;
        end
    end

    // Map byte is latched in the memory output register until taken.
    always_comb
    begin
        out_data          = s_item_reg;
        out_data.tx_valid = s_pull_reg.valid;
        out_data.tx_last  = s_pull_reg.last;
        out_data.tx_byte  = s_pull_reg.from_map ? rd_data : s_pull_reg.head_byte;
    end
    assign out_valid = s_valid_reg;

    ap_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s_valid_reg)
        else $error("input stalled with empty output stage");
    ap_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_pos_reg <= tx_len_reg)
        else $error("tx position beyond length");
    ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= CW'(MAX_FRAME + 1))
        else $error("rx count overflow");
    ap_feed_once: assert property (@(posedge clk) disable iff (!rst_n)
        s_crc_feed_reg |-> $past(pull_go))
        else $error("crc feed without pull");
endmodule
`default_nettype wire
